@@ src/srrle_pkg.sv @@
// Package for the sprite row run-length decoder.
// Holds register indexes, parse phase codes, decode constants and the run
// record shared by the core, the output buffer and the top level.
package srrle_pkg;

  localparam logic [1:0] CFG_CODING_MODE = 2'd0;
  localparam logic [1:0] CFG_ROW_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT   = 2'd2;

  localparam logic [1:0] MODE_UNCOMPRESSED = 2'd0;
  localparam logic [1:0] MODE_TWO_BYTE     = 2'd1;
  localparam logic [1:0] MODE_PACKED       = 2'd2;

  localparam logic [7:0] RAW_TYPE_WIDE   = 8'hFF;
  localparam logic [2:0] RAW_TYPE_PACKED = 3'h7;
  localparam logic [4:0] PACKED_LEN_MASK = 5'd31;

  localparam logic [15:0] RESET_ROW_WIDTH = 16'd32;
  localparam logic [15:0] RESET_ROW_COUNT = 16'd32;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_RAW    = 2'd2
  } phase_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] color_index;
    logic [8:0] run_length;
    logic       row_end;
    logic       frame_end;
  } run_t;

endpackage

@@ src/srrle_core.sv @@
// Decode core: configuration registers, segment parser and row/frame counters.
// Produces at most one run per accepted byte, in the same cycle.
// Depends on srrle_pkg.
module srrle_core
  import srrle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       in_take,
  input  logic [7:0] in_byte,
  output logic       res_push,
  output run_t       res
);

  logic [1:0]  coding_mode;
  logic [15:0] row_width;
  logic [15:0] row_count;

  phase_t      phase, phase_next;
  logic [7:0]  held_type, held_type_next;
  logic [8:0]  raw_remaining, raw_remaining_next;
  logic [16:0] row_filled, row_filled_next;
  logic [15:0] rows_done, rows_done_next;

  logic        emit;
  logic        seg_end;
  logic [7:0]  color;
  logic [8:0]  len;
  logic [8:0]  raw_dec;
  logic [8:0]  byte_len;
  logic [8:0]  packed_len;
  logic [16:0] filled_sum;
  logic [16:0] rows_inc;
  logic        row_end;
  logic        frame_end;

  assign raw_dec    = (raw_remaining != 9'd0) ? raw_remaining - 9'd1 : 9'd0;
  assign byte_len   = {1'b0, in_byte} + 9'd1;
  assign packed_len = {4'd0, in_byte[4:0] & PACKED_LEN_MASK} + 9'd1;

  // parser: next phase and the run this byte produces
  always_comb begin
    phase_next         = phase;
    held_type_next     = held_type;
    raw_remaining_next = raw_remaining;
    emit               = 1'b0;
    seg_end            = 1'b1;
    color              = in_byte;
    len                = 9'd1;
    if (coding_mode == MODE_UNCOMPRESSED) begin
      emit = 1'b1;
    end else if (phase == PH_RAW) begin
      raw_remaining_next = raw_dec;
      phase_next         = (raw_dec == 9'd0) ? PH_HEADER : PH_RAW;
      emit               = 1'b1;
      seg_end            = (raw_dec == 9'd0);
    end else if (coding_mode == MODE_TWO_BYTE) begin
      if (phase == PH_HEADER) begin
        held_type_next = in_byte;
        phase_next     = PH_LENGTH;
      end else begin
        phase_next = PH_HEADER;
        if (held_type == RAW_TYPE_WIDE) begin
          raw_remaining_next = byte_len;
          phase_next         = PH_RAW;
        end else begin
          emit  = 1'b1;
          color = held_type;
          len   = byte_len;
        end
      end
    end else begin
      phase_next = PH_HEADER;
      if (in_byte[7:5] == RAW_TYPE_PACKED) begin
        raw_remaining_next = packed_len;
        phase_next         = PH_RAW;
      end else begin
        emit  = 1'b1;
        color = {5'd0, in_byte[7:5]};
        len   = packed_len;
      end
    end
  end

  // row and frame counters
  assign filled_sum = row_filled + {8'd0, len};
  assign rows_inc   = {1'b0, rows_done} + 17'd1;
  assign row_end    = seg_end && (filled_sum >= {1'b0, row_width});
  assign frame_end  = row_end && (rows_inc >= {1'b0, row_count});

  always_comb begin
    row_filled_next = row_filled;
    rows_done_next  = rows_done;
    if (emit) begin
      row_filled_next = row_end ? 17'd0 : filled_sum;
      if (row_end) begin
        rows_done_next = frame_end ? 16'd0 : rows_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode   <= MODE_TWO_BYTE;
      row_width     <= RESET_ROW_WIDTH;
      row_count     <= RESET_ROW_COUNT;
      phase         <= PH_HEADER;
      held_type     <= 8'd0;
      raw_remaining <= 9'd0;
      row_filled    <= 17'd0;
      rows_done     <= 16'd0;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_CODING_MODE: begin
          coding_mode   <= cfg.data[1:0];
          phase         <= PH_HEADER;
          held_type     <= 8'd0;
          raw_remaining <= 9'd0;
        end
        CFG_ROW_WIDTH: row_width <= cfg.data;
        CFG_ROW_COUNT: row_count <= cfg.data;
        default: ;
      endcase
    end else if (in_take) begin
      phase         <= phase_next;
      held_type     <= held_type_next;
      raw_remaining <= raw_remaining_next;
      row_filled    <= row_filled_next;
      rows_done     <= rows_done_next;
    end
  end

  assign res_push        = in_take && !cfg.we && emit;
  assign res.color_index = color;
  assign res.run_length  = len;
  assign res.row_end     = row_end;
  assign res.frame_end   = frame_end;

  a_mode_write_clears: assert property (@(posedge clk) disable iff (rst)
    cfg.we && cfg.index == CFG_CODING_MODE |=> phase == PH_HEADER && raw_remaining == 9'd0)
    else $error("mode write did not clear the parser");

  a_raw_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RAW |-> raw_remaining != 9'd0)
    else $error("raw phase with no bytes left");

  a_row_end_clears: assert property (@(posedge clk) disable iff (rst)
    res_push && res.row_end |=> row_filled == 17'd0)
    else $error("row fill count not cleared at row end");

endmodule

@@ src/srrle_outbuf.sv @@
// Two-entry output buffer (output register plus skid register) for runs.
// Lets the decoder take a byte while a finished run still waits downstream.
// Depends on srrle_pkg.
module srrle_outbuf
  import srrle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  run_t push_run,
  output logic can_take,
  output logic out_valid,
  input  logic out_ready,
  output run_t out_run
);

  logic skid_valid;
  run_t skid_run;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign can_take = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_run <= skid_valid ? skid_run : push_run;
    end
    if (out_valid && !pop && push) begin
      skid_run <= push_run;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && !out_ready |=> skid_valid)
    else $error("stalled run not captured in skid");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    pop && !skid_valid && !push |=> !out_valid)
    else $error("output entry kept after drain");

endmodule

@@ src/sprite_row_rle_decoder.sv @@
// Sprite row run-length decoder, top level.
// A run appears on the master side in the cycle after its byte is taken
// when the output register is free.
// Throughput: one byte per cycle; the parser and counters update in one pass.
// A two-entry output buffer lets input flow on a stall until its skid fills.
// Reset (rst, synchronous): mode two-byte, width 32, rows 32, counters cleared.
// No clearing pass after reset; the block takes bytes from the next cycle.
// Depends on srrle_pkg, srrle_core, srrle_outbuf.
module sprite_row_rle_decoder
  import srrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // compressed byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  // decoded runs
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] color_index, [16:8] run_length, zero pad
  output logic        m_tlast,   // row_end
  output logic [0:0]  m_tuser    // [0] frame_end
);

  cfg_wr_t cfg;
  logic    take;
  logic    res_push;
  run_t    res;
  run_t    out_run;
  logic    can_take;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // hold input whenever the skid entry is occupied or a register is written
  assign s_tready = can_take && !cfg_we;
  assign take     = s_tvalid && s_tready;

  srrle_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_take  (take),
    .in_byte  (s_tdata),
    .res_push (res_push),
    .res      (res)
  );

  srrle_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_run  (res),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_run   (out_run)
  );

  assign m_tdata = {7'd0, out_run.run_length, out_run.color_index};
  assign m_tlast = out_run.row_end;
  assign m_tuser = out_run.frame_end;

endmodule
